// ===== design/chfi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the compact hash find-or-insert block.
// No dependencies; used by the channel interfaces, the hash unit and the top level.
package chfi_pkg;
   localparam int KEY_W    = 44;
   localparam int KW_W     = 6;
   localparam int STATUS_W = 2;
   localparam int HASH_W   = 32;
   localparam logic [KW_W-1:0] KW_RESET = 6'd44;

   localparam int CHG_BIT  = 0;
   localparam int VIRG_BIT = 1;
   localparam int OCC_BIT  = 2;
   localparam int FLAG_W   = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FOUND    = 2'd1,
      ST_TOO_WIDE = 2'd2,
      ST_NO_ROOM  = 2'd3
   } status_type;
endpackage

// ===== design/chfi_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests (keys) and responses (status).
// Depends on chfi_pkg.
interface chfi_req_if;
   import chfi_pkg::*;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key;
   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface chfi_rsp_if;
   import chfi_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

// ===== design/chfi_hash.sv =====
`timescale 1ns / 1ps
// Registered 32-bit hash of a 44-bit key (two mixing rounds, two avalanche steps).
// Depends on chfi_pkg.
module chfi_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [chfi_pkg::KEY_W-1:0]    key,
   output logic                          done,
   output logic [chfi_pkg::HASH_W-1:0]   hash
);
   import chfi_pkg::*;

   function automatic logic [HASH_W-1:0] mix_round(logic [HASH_W-1:0] h_i,
                                                   logic [15:0] lo, logic [15:0] hi);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] t;
      h = h_i + {16'd0, lo};
      t = ({16'd0, hi} << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] aval_a(logic [HASH_W-1:0] h_i);
      logic [HASH_W-1:0] h;
      h = h_i ^ (h_i << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] aval_b(logic [HASH_W-1:0] h_i);
      logic [HASH_W-1:0] h;
      h = h_i + (h_i >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

   logic [HASH_W-1:0] h_ff, h_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      h_in    = h_ff;
      key_in  = key_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         h_in    = mix_round('0, key[15:0], key[31:16]);
         key_in  = key;
         step_in = 2'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd1: h_in = mix_round(h_ff, {4'd0, key_ff[KEY_W-1:32]}, 16'd0);
            2'd2: h_in = aval_a(h_ff);
            default: begin
               h_in    = aval_b(h_ff);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      h_ff   <= h_in;
      key_ff <= key_in;
   end

   assign done = done_ff;
   assign hash = h_ff;
endmodule

// ===== design/chfi_store.sv =====
`timescale 1ns / 1ps
// Bucket store: simple dual-port synchronous RAM, registered read data.
// No dependencies.
module chfi_store #(
   parameter int DEPTH = 67584,
   parameter int AW    = 17,
   parameter int BW    = 31
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [BW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [BW-1:0] rd_data
);
   logic [BW-1:0] mem [DEPTH];
   logic [BW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/compact_hash_find_or_insert.sv =====
`timescale 1ns / 1ps
// Compact ordered hash table, find-or-insert of one key per request.
// Depends on chfi_pkg, chfi_if, chfi_hash and chfi_store.
//
// Usage: a request carries a 44-bit key on req_ch; the response on rsp_ch
// carries a 2-bit status (inserted, found, key too wide, no room). The
// csr_we / csr_wdata port sets key_width; the user must write it only while
// idle, which the block itself does not enforce. One request is in work at
// a time; a new request is taken as soon as the sequencer is idle, even
// while the previous response waits on rsp_ch. Steps: a too-wide key goes
// straight to the response. Otherwise the hash and the home read follow; a
// key whose home bucket is free is written there. Else come the left and
// right free-bucket scans, the count toward the nearer free bucket, the
// search, setup and the shift, then the final write, the group-end or
// home-flag update and the response. The single read port of the bucket
// store makes these steps run one after another.
// Reset: the store is cleared by a pass over all 2^INDEX_BITS + 2*SLACK
// buckets (67584 at the defaults), during which no request is taken.
// Stall: a finished response holds in the output register; the next
// request may be accepted and worked up to its own response meanwhile.
module compact_hash_find_or_insert #(
   parameter int INDEX_BITS = 16,
   parameter int REST_BITS  = 28,
   parameter int SLACK      = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   chfi_req_if.sink                   req_ch,
   chfi_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [chfi_pkg::KW_W-1:0]  csr_wdata
);
   import chfi_pkg::*;

   localparam int DEPTH = (2 ** INDEX_BITS) + 2 * SLACK;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = REST_BITS + FLAG_W;
   localparam int CW    = AW + 2;
   localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HOME, S_FL, S_FR,
      S_PR_CNT, S_PR_SRCH, S_PR_INIT, S_PR_CUR, S_PR_SHF,
      S_PL_CNT, S_PL_SRCH, S_PL_INIT, S_PL_CUR, S_PL_SHF,
      S_FINAL, S_FIX_PREV, S_HOME_RD, S_HOME_WR, S_FIN
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [KW_W-1:0]        kw_ff, kw_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [AW-1:0]          home_ff, home_in;
   logic [AW-1:0]          lft_ff, lft_in;
   logic [AW-1:0]          rgt_ff, rgt_in;
   logic [AW-1:0]          p_ff, p_in;
   logic signed [CW-1:0]   cnt_ff, cnt_in;
   logic signed [CW-1:0]   c2_ff, c2_in;
   logic [BW-1:0]          cur_ff, cur_in;
   logic [BW-1:0]          pv_ff, pv_in;
   logic                   hv_ff, hv_in;
   logic                   grp_ff, grp_in;
   logic                   right_ff, right_in;
   status_type             st_ff, st_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_st_ff, rsp_st_in;

   logic                   hash_start;
   logic                   hash_done;
   logic [HASH_W-1:0]      hash_val;

   logic                   mem_we, mem_re;
   logic [AW-1:0]          mem_wa, mem_ra;
   logic [BW-1:0]          mem_wd, mem_q;

   logic [REST_BITS-1:0]   q_rest;
   logic                   q_occ, q_virg, q_chg;
   logic [REST_BITS-1:0]   rest;
   logic signed [CW-1:0]   cnt_n, c2_n;
   logic [AW:0]            p_x, lft_x, rgt_x;
   logic                   too_wide;
   logic                   brk;
   logic                   set_home;
   logic                   chg_q;
   logic [AW-1:0]          home_calc;

   chfi_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_ch.key),
      .done  (hash_done),
      .hash  (hash_val)
   );

   chfi_store #(.DEPTH(DEPTH), .AW(AW), .BW(BW)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_q)
   );

   assign q_rest = mem_q[BW-1:FLAG_W];
   assign q_occ  = mem_q[OCC_BIT];
   assign q_virg = mem_q[VIRG_BIT];
   assign q_chg  = mem_q[CHG_BIT];
   assign rest   = key_ff[REST_BITS-1:0];
   assign p_x    = {1'b0, p_ff};
   assign lft_x  = {1'b0, lft_ff};
   assign rgt_x  = {1'b0, rgt_ff};
   assign too_wide = (req_ch.key >> kw_ff) != '0;
   assign home_calc = AW'(hash_val[INDEX_BITS-1:0]) + AW'(SLACK);

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_st_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kw_in        = csr_we ? csr_wdata : kw_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      lft_in       = lft_ff;
      rgt_in       = rgt_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      c2_in        = c2_ff;
      cur_in       = cur_ff;
      pv_in        = pv_ff;
      hv_in        = hv_ff;
      grp_in       = grp_ff;
      right_in     = right_ff;
      st_in        = st_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready);
      rsp_st_in    = rsp_st_ff;
      hash_start   = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = p_ff;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = p_ff;
      cnt_n        = '0;
      c2_n         = '0;
      brk          = 1'b0;
      set_home     = 1'b0;
      chg_q        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if ({1'b0, clr_ff} == DEPTH_X - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               key_in = req_ch.key;
               if (too_wide) begin
                  st_in    = ST_TOO_WIDE;
                  state_in = S_FIN;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               home_in  = home_calc;
               mem_re   = 1'b1;
               mem_ra   = home_calc;
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            if (!q_occ) begin
               mem_we   = 1'b1;
               mem_wa   = home_ff;
               mem_wd   = {rest, 3'b111};
               st_in    = ST_INSERTED;
               state_in = S_FIN;
            end else begin
               hv_in = q_virg;
               if (home_ff == '0) begin
                  st_in    = ST_NO_ROOM;
                  state_in = S_FIN;
               end else begin
                  p_in     = home_ff - 1'b1;
                  mem_re   = 1'b1;
                  mem_ra   = home_ff - 1'b1;
                  state_in = S_FL;
               end
            end
         end
         S_FL: begin
            if (!q_occ) begin
               lft_in = p_ff;
               if ({1'b0, home_ff} + 1'b1 < DEPTH_X) begin
                  p_in     = home_ff + 1'b1;
                  mem_re   = 1'b1;
                  mem_ra   = home_ff + 1'b1;
                  state_in = S_FR;
               end else begin
                  st_in    = ST_NO_ROOM;
                  state_in = S_FIN;
               end
            end else if (p_ff == '0) begin
               st_in    = ST_NO_ROOM;
               state_in = S_FIN;
            end else begin
               p_in   = p_ff - 1'b1;
               mem_re = 1'b1;
               mem_ra = p_ff - 1'b1;
            end
         end
         S_FR: begin
            if (!q_occ) begin
               rgt_in = p_ff;
               p_in   = home_ff;
               cnt_in = '0;
               mem_re = 1'b1;
               mem_ra = home_ff;
               grp_in = 1'b0;
               if ((home_ff - lft_ff) > (p_ff - home_ff)) begin
                  right_in = 1'b1;
                  state_in = S_PR_CNT;
               end else begin
                  right_in = 1'b0;
                  state_in = S_PL_CNT;
               end
            end else if (p_x + 1'b1 >= DEPTH_X) begin
               st_in    = ST_NO_ROOM;
               state_in = S_FIN;
            end else begin
               p_in   = p_ff + 1'b1;
               mem_re = 1'b1;
               mem_ra = p_ff + 1'b1;
            end
         end
         S_PR_CNT: begin
            cnt_n  = cnt_ff - CW'(q_virg);
            cnt_in = cnt_n;
            if (p_x + 1'b1 < rgt_x) begin
               p_in   = p_ff + 1'b1;
               mem_re = 1'b1;
               mem_ra = p_ff + 1'b1;
            end else if (hv_ff && (cnt_n < 1) && (p_ff > lft_ff)) begin
               c2_in    = cnt_n;
               mem_re   = 1'b1;
               mem_ra   = p_ff;
               state_in = S_PR_SRCH;
            end else begin
               state_in = S_PR_INIT;
            end
         end
         S_PR_SRCH: begin
            c2_n = c2_ff + CW'(q_chg);
            if (!q_occ) begin
               state_in = S_PR_INIT;
            end else if (c2_n == 0 && q_rest < rest) begin
               state_in = S_PR_INIT;
            end else if (c2_n == 0 && q_rest == rest) begin
               st_in    = ST_FOUND;
               state_in = S_FIN;
            end else begin
               c2_in = c2_n;
               p_in  = p_ff - 1'b1;
               if ((c2_n < 1) && (p_ff - 1'b1 > lft_ff)) begin
                  mem_re = 1'b1;
                  mem_ra = p_ff - 1'b1;
               end else begin
                  state_in = S_PR_INIT;
               end
            end
         end
         S_PR_INIT: begin
            p_in     = rgt_ff;
            mem_re   = 1'b1;
            mem_ra   = rgt_ff;
            state_in = S_PR_CUR;
         end
         S_PR_CUR: begin
            cur_in   = mem_q;
            mem_re   = 1'b1;
            mem_ra   = p_ff - 1'b1;
            state_in = S_PR_SHF;
         end
         S_PR_SHF: begin
            cnt_n  = cnt_ff + CW'(q_chg);
            cnt_in = cnt_n;
            brk = (hv_ff && cnt_n == 0 && q_rest < rest) || (cnt_n == 1) ||
                  (cnt_n == 0 && !q_occ) || (p_x <= lft_x + 1'b1);
            if (brk) begin
               pv_in    = mem_q;
               state_in = S_FINAL;
            end else begin
               if (cnt_n == 0) begin
                  grp_in = 1'b1;
               end
               mem_we = 1'b1;
               mem_wa = p_ff;
               mem_wd = {q_rest, 1'b1, cur_ff[VIRG_BIT], q_chg};
               cur_in = mem_q;
               p_in   = p_ff - 1'b1;
               mem_re = 1'b1;
               mem_ra = p_ff - 2'd2;
            end
         end
         S_PL_CNT: begin
            cnt_n  = cnt_ff - CW'(q_virg);
            cnt_in = cnt_n;
            if (p_ff - 1'b1 > lft_ff) begin
               p_in   = p_ff - 1'b1;
               mem_re = 1'b1;
               mem_ra = p_ff - 1'b1;
            end else if (hv_ff && (cnt_n < 0) && (lft_x + 1'b1 < rgt_x)) begin
               c2_in    = cnt_n;
               p_in     = lft_ff + 1'b1;
               mem_re   = 1'b1;
               mem_ra   = lft_ff + 1'b1;
               state_in = S_PL_SRCH;
            end else begin
               state_in = S_PL_INIT;
            end
         end
         S_PL_SRCH: begin
            c2_n = c2_ff + CW'(q_chg);
            if (!q_occ) begin
               state_in = S_PL_INIT;
            end else if (c2_ff == -1 && q_rest > rest) begin
               state_in = S_PL_INIT;
            end else if (c2_ff == -1 && q_rest == rest) begin
               st_in    = ST_FOUND;
               state_in = S_FIN;
            end else begin
               c2_in = c2_n;
               p_in  = p_ff + 1'b1;
               if ((c2_n < 0) && (p_x + 1'b1 < rgt_x)) begin
                  mem_re = 1'b1;
                  mem_ra = p_ff + 1'b1;
               end else begin
                  state_in = S_PL_INIT;
               end
            end
         end
         S_PL_INIT: begin
            p_in     = lft_ff;
            mem_re   = 1'b1;
            mem_ra   = lft_ff;
            state_in = S_PL_CUR;
         end
         S_PL_CUR: begin
            cur_in = mem_q;
            if (p_x + 1'b1 >= rgt_x) begin
               state_in = S_FINAL;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = p_ff + 1'b1;
               state_in = S_PL_SHF;
            end
         end
         S_PL_SHF: begin
            brk = (hv_ff && cnt_ff == -1 && q_rest > rest) || (cnt_ff == 0);
            if (brk) begin
               state_in = S_FINAL;
            end else begin
               cnt_n  = cnt_ff + CW'(q_chg);
               cnt_in = cnt_n;
               mem_we = 1'b1;
               mem_wa = p_ff;
               mem_wd = {q_rest, 1'b1, cur_ff[VIRG_BIT],
                         (hv_ff && cnt_n == 0) ? 1'b0 : q_chg};
               cur_in = mem_q;
               p_in   = p_ff + 1'b1;
               if (p_x + 2'd2 >= rgt_x) begin
                  state_in = S_FINAL;
               end else begin
                  mem_re = 1'b1;
                  mem_ra = p_ff + 2'd2;
               end
            end
         end
         S_FINAL: begin
            if (right_ff) begin
               set_home = !hv_ff;
               chg_q    = !hv_ff || !grp_ff;
            end else begin
               set_home = (cnt_ff == 0);
               chg_q    = (cnt_ff == 0);
            end
            mem_we = 1'b1;
            mem_wa = p_ff;
            mem_wd = {rest, 1'b1, cur_ff[VIRG_BIT] | (set_home && p_ff == home_ff), chg_q};
            st_in  = ST_INSERTED;
            if (right_ff && hv_ff && !grp_ff) begin
               state_in = S_FIX_PREV;
            end else if (set_home && p_ff != home_ff) begin
               state_in = S_HOME_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIX_PREV: begin
            mem_we   = 1'b1;
            mem_wa   = p_ff - 1'b1;
            mem_wd   = {pv_ff[BW-1:1], 1'b0};
            state_in = S_FIN;
         end
         S_HOME_RD: begin
            mem_re   = 1'b1;
            mem_ra   = home_ff;
            state_in = S_HOME_WR;
         end
         S_HOME_WR: begin
            mem_we   = 1'b1;
            mem_wa   = home_ff;
            mem_wd   = mem_q | BW'(1 << VIRG_BIT);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (state_ff == S_IDLE && req_ch.valid && !too_wide) begin
         hash_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         kw_ff        <= KW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         kw_ff        <= kw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff    <= key_in;
      home_ff   <= home_in;
      lft_ff    <= lft_in;
      rgt_ff    <= rgt_in;
      p_ff      <= p_in;
      cnt_ff    <= cnt_in;
      c2_ff     <= c2_in;
      cur_ff    <= cur_in;
      pv_ff     <= pv_in;
      hv_ff     <= hv_in;
      grp_ff    <= grp_in;
      right_ff  <= right_in;
      st_ff     <= st_in;
      rsp_st_ff <= rsp_st_in;
   end

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_wa != mem_ra))
      else $error("store read and write hit the same bucket");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request taken during store clear");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_wa} < DEPTH_X))
      else $error("store write beyond depth");
endmodule

// ===== tb/chfi_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side helpers for the compact hash find-or-insert bench.
// Depends on chfi_pkg.
package chfi_tb_pkg;
   import chfi_pkg::*;
   localparam int TB_INDEX_BITS = 16;
   localparam int TB_REST_BITS  = 28;
   localparam int TB_SLACK      = 1024;
   localparam int TB_DEPTH      = (1 << TB_INDEX_BITS) + 2 * TB_SLACK;
endpackage

// ===== tb/compact_hash_find_or_insert_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for compact_hash_find_or_insert: directed and random keys,
// key_width settings, random idling and a long response stall; predicts each status.
// Depends on chfi_pkg, chfi_tb_pkg, chfi_if and the top level.
module compact_hash_find_or_insert_tb;
   import chfi_pkg::*;
   import chfi_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [KW_W-1:0] csr_wdata = '0;

   chfi_req_if req_ch ();
   chfi_rsp_if rsp_ch ();

   compact_hash_find_or_insert uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [TB_REST_BITS-1:0] rest;
      logic occ;
      logic virg;
      logic chg;
   } bucket_type;

   bucket_type table_m [TB_DEPTH];
   logic [KW_W-1:0] width_m;
   status_type status_q [$];
   logic [KEY_W-1:0] keys_seen [$];
   int errors = 0;
   int requests = 0;
   int responses = 0;
   longint cycles = 0;
   bit hold_rsp = 1'b0;
   int count_st [4];

   function automatic logic [31:0] sfh(logic [63:0] k);
      logic [31:0] h, lo, hi, t;
      h = 0;
      for (int i = 0; i < 2; i++) begin
         lo = 32'(k[32*i +: 16]);
         hi = 32'(k[32*i+16 +: 16]);
         h = h + lo;
         t = (hi << 11) ^ h;
         h = (h << 16) ^ t;
         h = h + (h >> 11);
      end
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

   function automatic status_type shift_right_in(int home, int lft, int rgt,
                                                 logic [TB_REST_BITS-1:0] r);
      int count, j, q, c2;
      int in_group;
      count = 0;
      in_group = 0;
      j = home;
      while (j < rgt) begin
         count -= table_m[j].virg;
         j++;
      end
      if (table_m[home].virg) begin
         c2 = count;
         j--;
         while (c2 < 1 && j > lft && table_m[j].occ) begin
            c2 += table_m[j].chg;
            if (c2 == 0) begin
               if (table_m[j].rest < r) break;
               if (table_m[j].rest == r) return ST_FOUND;
            end
            j--;
         end
      end
      q = rgt;
      forever begin
         count += table_m[q-1].chg;
         if ((table_m[home].virg && count == 0 && table_m[q-1].rest < r) ||
             count == 1 || (count == 0 && !table_m[q-1].occ) || q <= lft + 1)
            break;
         if (count == 0) in_group++;
         table_m[q].rest = table_m[q-1].rest;
         table_m[q].chg = table_m[q-1].chg;
         table_m[q].occ = 1'b1;
         q--;
      end
      table_m[q].rest = r;
      table_m[q].occ = 1'b1;
      if (!table_m[home].virg) begin
         table_m[home].virg = 1'b1;
         table_m[q].chg = 1'b1;
      end else if (in_group == 0) begin
         table_m[q-1].chg = 1'b0;
         table_m[q].chg = 1'b1;
      end else begin
         table_m[q].chg = 1'b0;
      end
      return ST_INSERTED;
   endfunction

   function automatic status_type shift_left_in(int home, int lft, int rgt,
                                                logic [TB_REST_BITS-1:0] r);
      int count, j, q, c2;
      count = 0;
      j = home;
      while (j > lft) begin
         count -= table_m[j].virg;
         j--;
      end
      if (table_m[home].virg) begin
         c2 = count;
         j++;
         while (c2 < 0 && j < rgt && table_m[j].occ) begin
            if (c2 == -1) begin
               if (table_m[j].rest > r) break;
               if (table_m[j].rest == r) return ST_FOUND;
            end
            c2 += table_m[j].chg;
            j++;
         end
      end
      q = lft;
      forever begin
         if (q + 1 >= rgt) break;
         if ((table_m[home].virg && count == -1 && table_m[q+1].rest > r) || count == 0)
            break;
         table_m[q].rest = table_m[q+1].rest;
         table_m[q].chg = table_m[q+1].chg;
         table_m[q].occ = 1'b1;
         count += table_m[q+1].chg;
         if (table_m[home].virg && count == 0) table_m[q].chg = 1'b0;
         q++;
      end
      table_m[q].rest = r;
      table_m[q].occ = 1'b1;
      if (count == 0) begin
         table_m[home].virg = 1'b1;
         table_m[q].chg = 1'b1;
      end else begin
         table_m[q].chg = 1'b0;
      end
      return ST_INSERTED;
   endfunction

   function automatic status_type find_or_insert(logic [KEY_W-1:0] key);
      int home, lft, rgt, p;
      logic [TB_REST_BITS-1:0] r;
      logic [63:0] k64;
      k64 = 64'(key);
      if (width_m < KEY_W && (k64 >> width_m) != 0) return ST_TOO_WIDE;
      home = int'(sfh(k64) & ((1 << TB_INDEX_BITS) - 1)) + TB_SLACK;
      r = key[TB_REST_BITS-1:0];
      if (!table_m[home].occ) begin
         table_m[home] = '{rest: r, occ: 1'b1, virg: 1'b1, chg: 1'b1};
         return ST_INSERTED;
      end
      lft = -1;
      for (p = home - 1; p >= 0; p--)
         if (!table_m[p].occ) begin
            lft = p;
            break;
         end
      rgt = -1;
      for (p = home + 1; p < TB_DEPTH; p++)
         if (!table_m[p].occ) begin
            rgt = p;
            break;
         end
      if (lft < 0 || rgt < 0) return ST_NO_ROOM;
      if ((home - lft) - (rgt - home) > 0) return shift_right_in(home, lft, rgt, r);
      return shift_left_in(home, lft, rgt, r);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3000000) begin
         $display("%0t: timeout", $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // accept responses, with random stalls and a long hold when asked
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_ch.ready <= 1'b0;
      end
   end

   // check each response against the oldest expected status
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses++;
         if (status_q.size() == 0) begin
            $display("%0t: unexpected response, actual %0d", $time, rsp_ch.status);
            errors++;
         end else begin
            want = status_q.pop_front();
            if (rsp_ch.status !== want) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want, rsp_ch.status);
               errors++;
            end
         end
      end
   end

   task automatic send_key(logic [KEY_W-1:0] key, bit idle_ok = 1'b1);
      int gap;
      status_type st;
      gap = 0;
      if (idle_ok)
         gap = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      st = find_or_insert(key);
      status_q.push_back(st);
      count_st[st]++;
      keys_seen.push_back(key);
      requests++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_width(int w);
      csr_we <= 1'b1;
      csr_wdata <= KW_W'(w);
      @(posedge clock);
      csr_we <= 1'b0;
      width_m = KW_W'(w);
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      return KEY_W'({$urandom(), $urandom()});
   endfunction

   task automatic test_directed();
      send_key('0);
      send_key('0);
      send_key({KEY_W{1'b1}});
      send_key({KEY_W{1'b1}});
      for (int i = 0; i < KEY_W; i += 4) send_key(KEY_W'(1) << i);
      send_key(44'h5555_5555_555);
      send_key(44'hAAA_AAAA_AAAA);
      // same remainder, different upper bits
      send_key(44'h123_0ABC_DEF);
      send_key(44'h777_0ABC_DEF);
      send_key(44'h123_0ABC_DEF);
      settle();
   endtask

   task automatic test_width_limits();
      set_width(1);
      send_key(44'h0);
      send_key(44'h1);
      send_key(44'h2);
      send_key({KEY_W{1'b1}});
      settle();
      set_width(0);
      send_key(44'h0);
      send_key(44'h1);
      settle();
      set_width(63);
      send_key({KEY_W{1'b1}});
      send_key(44'h800_0000_0000);
      settle();
      set_width(12);
      for (int i = 0; i < 8; i++) send_key(KEY_W'($urandom_range(0, 8191)));
      settle();
      set_width(44);
   endtask

   task automatic test_clusters(int n);
      logic [KEY_W-1:0] k;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: k = keys_seen[$urandom_range(0, keys_seen.size() - 1)];
            3, 4: k = KEY_W'($urandom_range(0, 4095));
            5: k = rand_key() & {KEY_W{1'b1}} >> $urandom_range(0, 43);
            default: k = rand_key();
         endcase
         send_key(k);
      end
      settle();
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 20; i++) send_key(rand_key(), 1'b0);
      settle();
   endtask

   task automatic test_narrow_random(int w, int n);
      int sh;
      sh = (w < KEY_W) ? KEY_W - w - 1 : 0;
      set_width(w);
      for (int i = 0; i < n; i++)
         send_key(($urandom_range(0, 3) == 0) ? rand_key() : rand_key() >> sh);
      settle();
   endtask

   initial begin
      for (int i = 0; i < TB_DEPTH; i++) table_m[i] = '0;
      width_m = KW_RESET;
      req_ch.valid = 1'b0;
      req_ch.key = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_width_limits();
      test_backpressure();
      test_clusters(600);
      test_narrow_random(20, 300);
      test_narrow_random(44, 100);
      test_clusters(300);
      $display("Covered %0d requests, %0d responses: inserted %0d, found %0d, too wide %0d,",
               requests, responses, count_st[0], count_st[1], count_st[2]);
      $display("no room %0d, over key widths 0, 1, 12, 20, 44 and 63.", count_st[3]);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
